// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define ASSERT_SAME(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/fup_pkg.sv =====
`default_nettype none
package fup_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HOST_ADDRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_GROUP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LENGTH = 3'd3;

  localparam logic [7:0] MAX_FRAME_LENGTH_RST = 8'd64;
  localparam logic [7:0] HEADER_LEN           = 8'd6;
  localparam logic [7:0] WITH_SUB_LEN         = 8'd7;

  typedef struct packed {
    logic [7:0] host_address;
    logic [7:0] device_address;
    logic [7:0] accepted_group;
    logic [7:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       frame_end;
    logic       checksum_match;
    logic       frame_ready;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/fup_cfg_regs.sv =====
`default_nettype none
module fup_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [fup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  output fup_pkg::cfg_t                      cfg
);
  import fup_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.host_address     <= '0;
      cfg.device_address   <= '0;
      cfg.accepted_group   <= '0;
      cfg.max_frame_length <= MAX_FRAME_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HOST_ADDRESS:     cfg.host_address     <= cfg_data;
        REG_DEVICE_ADDRESS:   cfg.device_address   <= cfg_data;
        REG_ACCEPTED_GROUP:   cfg.accepted_group   <= cfg_data;
        REG_MAX_FRAME_LENGTH: cfg.max_frame_length <= cfg_data;
        default: ;  // unmapped index
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fup_parser.sv =====
`default_nettype none
module fup_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fup_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  output logic               res_valid,
  input  wire logic          res_ready,
  output fup_pkg::res_t      res
);
  import fup_pkg::*;

  typedef enum logic [2:0] {
    PH_HOST, PH_DEV, PH_LEN, PH_SEQ, PH_GROUP, PH_SUB, PH_DATA, PH_CSUM
  } phase_t;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] write_position, write_position_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] frame_group, frame_group_next;
  logic [7:0] sub_left;
  logic       advance;
  logic       store;

  assign advance   = in_full && res_ready;
  assign in_ready  = !in_full || res_ready;
  assign res_valid = in_full;
  assign sub_left  = bytes_left - WITH_SUB_LEN;

  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    write_position_next = write_position;
    bytes_left_next     = bytes_left;
    frame_group_next    = frame_group;
    store               = 1'b0;
    res                 = '0;

    unique case (phase)
      PH_HOST: begin
        if (in_byte == cfg.host_address) begin
          running_xor_next    = in_byte;
          write_position_next = 8'd1;
          store               = 1'b1;
          res.store_index     = '0;
          phase_next          = PH_DEV;
        end
      end
      PH_DEV: begin
        if (in_byte == cfg.device_address) begin
          running_xor_next = running_xor ^ in_byte;
          store            = 1'b1;
          phase_next       = PH_LEN;
        end else if (in_byte == cfg.host_address) begin
          running_xor_next = in_byte;  // restart checksum, keep position
        end else begin
          phase_next = PH_HOST;
        end
      end
      PH_LEN: begin
        bytes_left_next  = in_byte;
        running_xor_next = running_xor ^ in_byte;
        store            = 1'b1;
        phase_next       = (in_byte <= cfg.max_frame_length) ? PH_SEQ : PH_HOST;
      end
      PH_SEQ: begin
        running_xor_next = running_xor ^ in_byte;
        store            = 1'b1;
        phase_next       = PH_GROUP;
      end
      PH_GROUP: begin
        frame_group_next = in_byte;
        running_xor_next = running_xor ^ in_byte;
        store            = 1'b1;
        if (bytes_left < HEADER_LEN)       phase_next = PH_HOST;
        else if (bytes_left == HEADER_LEN) phase_next = PH_CSUM;
        else                               phase_next = PH_SUB;
      end
      PH_SUB: begin
        bytes_left_next  = sub_left;
        running_xor_next = running_xor ^ in_byte;
        store            = 1'b1;
        phase_next       = (sub_left != '0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        bytes_left_next  = bytes_left - 8'd1;
        running_xor_next = running_xor ^ in_byte;
        store            = 1'b1;
        if (bytes_left == 8'd1) phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        store              = 1'b1;
        res.frame_end      = 1'b1;
        res.checksum_match = (running_xor == in_byte);
        res.frame_ready    = (running_xor == in_byte)
                             && (frame_group == cfg.accepted_group);
        phase_next         = PH_HOST;
      end
      default: phase_next = PH_HOST;
    endcase

    // every stored byte except host and checksum advances the position
    if (store && phase != PH_HOST && phase != PH_CSUM) begin
      write_position_next = write_position + 8'd1;
    end
    if (store && phase != PH_HOST) begin
      res.store_index = write_position;
    end
    res.store_valid = store;
    res.store_byte  = store ? in_byte : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      phase          <= PH_HOST;
      running_xor    <= '0;
      write_position <= '0;
      bytes_left     <= '0;
      frame_group    <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        phase          <= phase_next;
        running_xor    <= running_xor_next;
        write_position <= write_position_next;
        bytes_left     <= bytes_left_next;
        frame_group    <= frame_group_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fup_out_reg.sv =====
`default_nettype none
module fup_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  output logic               res_ready,
  input  wire fup_pkg::res_t res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fup_pkg::res_t      out_res
);
  import fup_pkg::*;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/framed_uart_packet_parser_top.sv =====
`default_nettype none
// Framed serial packet parser. Takes one received byte per item on the input
// channel and returns exactly one result item per byte: whether and where the
// byte goes into the frame buffer, and at the checksum byte the frame end,
// checksum match and ready flags. Throughput is one byte per cycle while the
// output side takes results. A result passes the input register, then the
// result register fed by the combinational parse update, before it is valid at
// the output. The result register frees as the output is taken, so input flow
// stalls only when the output side holds back. Registers (index 0..3: host
// address, device address, accepted group, max frame length) are written with
// cfg_write; the user must write them only while no item is in flight, as the
// block itself does not enforce it. Other indexes are ignored.
module framed_uart_packet_parser_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [fup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               store_valid,
  output logic [7:0]                         store_index,
  output logic [7:0]                         store_byte,
  output logic                               frame_end,
  output logic                               checksum_match,
  output logic                               frame_ready
);
  import fup_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic res_ready;

  fup_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fup_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fup_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign store_valid    = out_res.store_valid;
  assign store_index    = out_res.store_index;
  assign store_byte     = out_res.store_byte;
  assign frame_end      = out_res.frame_end;
  assign checksum_match = out_res.checksum_match;
  assign frame_ready    = out_res.frame_ready;

endmodule
`default_nettype wire

// ===== rtl/fup_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module fup_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       store_valid,
  input wire logic [7:0] store_index,
  input wire logic [7:0] store_byte,
  input wire logic       frame_end,
  input wire logic       checksum_match,
  input wire logic       frame_ready
);

  // a byte that is not stored carries nothing else
  `ASSERT_SAME(a_unstored_clear, clk, rst, out_valid && !store_valid, store_index == 8'd0 && store_byte == 8'd0 && !frame_end)

  // checksum byte is always stored; flags only at frame end
  `ASSERT_SAME(a_end_stored, clk, rst, out_valid && frame_end, store_valid)
  `ASSERT_SAME(a_flags_at_end, clk, rst, out_valid && (checksum_match || frame_ready), frame_end && checksum_match)

  // a stalled result stays valid and keeps its index, byte and frame end
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(store_index) && $stable(store_byte) && $stable(frame_end))

  // nothing pending on either side means input is open
  `ASSERT_NEXT(a_drain_ready, clk, rst, !out_valid && !in_valid && in_ready, in_ready)

endmodule

bind framed_uart_packet_parser_top fup_checker u_fup_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .store_valid    (store_valid),
  .store_index    (store_index),
  .store_byte     (store_byte),
  .frame_end      (frame_end),
  .checksum_match (checksum_match),
  .frame_ready    (frame_ready)
);
`default_nettype wire

// ===== tb/frame_parse_scoreboard.sv =====
`timescale 1ns / 1ps
module frame_parse_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          store_valid,
  input  logic [7:0]                    store_index,
  input  logic [7:0]                    store_byte,
  input  logic                          frame_end,
  input  logic                          checksum_match,
  input  logic                          frame_ready,
  output int                            pending,
  output int                            failures
);
  import fup_pkg::*;

  typedef enum logic [2:0] {
    WAIT_HOST,
    WAIT_DEVICE,
    WAIT_LENGTH,
    WAIT_SEQUENCE,
    WAIT_GROUP,
    WAIT_SUB_ID,
    IN_DATA,
    WAIT_CHECKSUM
  } parse_state_t;

  logic [7:0]   host_addr;
  logic [7:0]   dev_addr;
  logic [7:0]   want_group;
  logic [7:0]   max_len;

  parse_state_t phase;
  logic [7:0]   xor_acc;
  logic [7:0]   wr_pos;
  logic [7:0]   len_left;
  logic [7:0]   seen_group;

  res_t         predicted_results[$];
  int           fail_count = 0;

  initial pending = 0;
  assign failures = fail_count;

  // Advances the parser state by one byte and returns the result it produces.
  function automatic res_t parse_byte(input logic [7:0] b);
    res_t r;
    bit   keep;
    bit   advance;
    r       = '0;
    keep    = 1'b1;
    advance = 1'b1;
    case (phase)
      WAIT_HOST: begin
        keep = (b == host_addr);
        if (keep) begin
          xor_acc = b;
          wr_pos  = '0;
          phase   = WAIT_DEVICE;
        end
      end
      WAIT_DEVICE: begin
        keep = (b == dev_addr);
        if (keep) begin
          xor_acc ^= b;
          phase = WAIT_LENGTH;
        end else if (b == host_addr) begin
          // host byte again: checksum restarts, position is kept
          xor_acc = b;
        end else begin
          phase = WAIT_HOST;
        end
      end
      WAIT_LENGTH: begin
        len_left = b;
        xor_acc ^= b;
        phase = (b <= max_len) ? WAIT_SEQUENCE : WAIT_HOST;
      end
      WAIT_SEQUENCE: begin
        xor_acc ^= b;
        phase = WAIT_GROUP;
      end
      WAIT_GROUP: begin
        seen_group = b;
        xor_acc ^= b;
        if (len_left < HEADER_LEN)
          phase = WAIT_HOST;
        else if (len_left == HEADER_LEN)
          phase = WAIT_CHECKSUM;
        else
          phase = WAIT_SUB_ID;
      end
      WAIT_SUB_ID: begin
        len_left = len_left - WITH_SUB_LEN;
        xor_acc ^= b;
        phase = (len_left != 0) ? IN_DATA : WAIT_CHECKSUM;
      end
      IN_DATA: begin
        xor_acc ^= b;
        len_left = len_left - 8'd1;
        if (len_left == 0)
          phase = WAIT_CHECKSUM;
      end
      default: begin
        advance          = 1'b0;
        r.frame_end      = 1'b1;
        r.checksum_match = (xor_acc == b);
        r.frame_ready    = r.checksum_match && (seen_group == want_group);
        phase            = WAIT_HOST;
      end
    endcase
    if (keep) begin
      r.store_valid = 1'b1;
      r.store_index = wr_pos;
      r.store_byte  = b;
      if (advance)
        wr_pos = wr_pos + 8'd1;
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      host_addr  = '0;
      dev_addr   = '0;
      want_group = '0;
      max_len    = MAX_FRAME_LENGTH_RST;
      phase      = WAIT_HOST;
      xor_acc    = '0;
      wr_pos     = '0;
      len_left   = '0;
      seen_group = '0;
      predicted_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HOST_ADDRESS:     host_addr  = cfg_data;
          REG_DEVICE_ADDRESS:   dev_addr   = cfg_data;
          REG_ACCEPTED_GROUP:   want_group = cfg_data;
          REG_MAX_FRAME_LENGTH: max_len    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_results.push_back(parse_byte(rx_byte));
      if (out_valid && out_ready) begin
        got = {store_valid, store_index, store_byte, frame_end, checksum_match, frame_ready};
        if (predicted_results.size() == 0) begin
          $error("result item with no prediction pending");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("store_valid", 8'(want.store_valid), 8'(got.store_valid));
          compare_field("store_index", want.store_index, got.store_index);
          compare_field("store_byte", want.store_byte, got.store_byte);
          compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
          compare_field("checksum_match", 8'(want.checksum_match),
                        8'(got.checksum_match));
          compare_field("frame_ready", 8'(want.frame_ready), 8'(got.frame_ready));
        end
      end
    end
    pending <= predicted_results.size();
  end

endmodule

// ===== tb/framed_uart_packet_parser_top_test.sv =====
`timescale 1ns / 1ps
module framed_uart_packet_parser_top_test;
  import fup_pkg::*;

  localparam int                   CYCLE_LIMIT = 400000;
  localparam int                   PHASE_BYTES = 240;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 store_valid;
  logic [7:0]           store_index;
  logic [7:0]           store_byte;
  logic                 frame_end;
  logic                 checksum_match;
  logic                 frame_ready;

  int                   pending;
  int                   failures;
  int                   cycle_count = 0;
  int                   idle_pct = 9;
  int                   stall_pct = 9;
  int                   sent_bytes = 0;

  // stimulus-side copy of the programmed registers
  logic [7:0]           cur_host;
  logic [7:0]           cur_dev;
  logic [7:0]           cur_group;
  logic [7:0]           cur_max;
  logic [7:0]           frame_xor;

  framed_uart_packet_parser_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .store_valid    (store_valid),
    .store_index    (store_index),
    .store_byte     (store_byte),
    .frame_end      (frame_end),
    .checksum_match (checksum_match),
    .frame_ready    (frame_ready)
  );

  frame_parse_scoreboard scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .store_valid    (store_valid),
    .store_index    (store_index),
    .store_byte     (store_byte),
    .frame_end      (frame_end),
    .checksum_match (checksum_match),
    .frame_ready    (frame_ready),
    .pending        (pending),
    .failures       (failures)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] host, input logic [7:0] dev,
                            input logic [7:0] grp, input logic [7:0] max_len);
    cur_host  = host;
    cur_dev   = dev;
    cur_group = grp;
    cur_max   = max_len;
    write_reg(REG_HOST_ADDRESS, host);
    write_reg(REG_DEVICE_ADDRESS, dev);
    write_reg(REG_ACCEPTED_GROUP, grp);
    write_reg(REG_MAX_FRAME_LENGTH, max_len);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    frame_xor = frame_xor ^ b;
    sent_bytes++;
  endtask

  // Sends a frame of total length len; stops where the parser gives up on it.
  task automatic send_frame(input int len, input int host_repeats, input bit corrupt,
                            input bit grp_match);
    logic [7:0] grp;
    send_byte(cur_host);
    if (cur_host != cur_dev)
      repeat (host_repeats) send_byte(cur_host);
    frame_xor = cur_host;
    send_byte(cur_dev);
    send_byte(len[7:0]);
    if (len > cur_max)
      return;
    send_byte(8'($urandom));
    grp = grp_match ? cur_group : 8'($urandom);
    send_byte(grp);
    if (len < HEADER_LEN)
      return;
    // sub-id and data bytes
    if (len > HEADER_LEN)
      repeat (len - HEADER_LEN) send_byte(8'($urandom));
    if (corrupt)
      send_byte(frame_xor ^ (8'd1 << $urandom_range(7)));
    else
      send_byte(frame_xor);
  endtask

  task automatic send_wrong_device();
    logic [7:0] bad;
    send_byte(cur_host);
    do bad = 8'($urandom); while (bad == cur_dev || bad == cur_host);
    send_byte(bad);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom);
      if (b == cur_host && $urandom_range(1) == 0)
        b = ~b;
      send_byte(b);
    end
  endtask

  // Mostly short frames, now and then one up to the buffer limit.
  function automatic int pick_len();
    int top_len;
    top_len = (cur_max < 16) ? cur_max : 16;
    if ($urandom_range(19) == 0)
      return $urandom_range(HEADER_LEN, cur_max);
    return $urandom_range(HEADER_LEN, top_len);
  endfunction

  // Waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int start;
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed
    set_config(8'hA5, 8'h5A, 8'h3C, 8'd64);
    send_byte(8'hFF);
    send_wrong_device();
    send_frame(5, 1, 1'b0, 1'b1);
    send_frame(200, 0, 1'b0, 1'b1);
    send_frame(6, 0, 1'b0, 1'b1);
    send_frame(7, 0, 1'b1, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain();
      idle_pct  = 9;
      stall_pct = 9;
      case (p)
        0: write_reg(REG_SPARE, 8'($urandom));
        1: set_config(8'h00, 8'hFF, 8'h00, 8'd255);
        2: set_config(8'hFF, 8'h00, 8'hFF, 8'd6);
        3: set_config(8'h7E, 8'h7E, 8'($urandom), 8'($urandom_range(6, 255)));
        4: begin
          idle_pct  = 0;
          stall_pct = 0;
          set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(6, 255)));
        end
        default:
          set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(6, 255)));
      endcase
      start = sent_bytes;
      while (sent_bytes - start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 65)
          send_frame(pick_len(), 0, 1'b0, $urandom_range(3) != 0);
        else if (pick < 72)
          send_frame(pick_len(), 0, 1'b1, 1'b1);
        else if (pick < 77)
          send_wrong_device();
        else if (pick < 82)
          send_frame(pick_len(), $urandom_range(1, 3), 1'b0, 1'b1);
        else if (pick < 87 && cur_max != 8'd255)
          send_frame($urandom_range(cur_max + 1, 255), 0, 1'b0, 1'b1);
        else if (pick < 91)
          send_frame($urandom_range(0, HEADER_LEN - 1), 0, 1'b0, 1'b1);
        else
          send_noise();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fup_pkg.sv
rtl/fup_cfg_regs.sv
rtl/fup_parser.sv
rtl/fup_out_reg.sv
rtl/framed_uart_packet_parser_top.sv
rtl/fup_checker.sv
tb/frame_parse_scoreboard.sv
tb/framed_uart_packet_parser_top_test.sv
